// ===== hdl/tte_pkg.sv =====
// shared constants, codes and types of the transposition table engine
package tte_pkg;

    localparam int ENTRIES     = 65536;
    localparam int DEPTH_LIMIT = 64;
    localparam int IDX_W       = $clog2(ENTRIES);

    localparam int KEY_W   = 64;
    localparam int MOVE_W  = 25;
    localparam int SCORE_W = 16;
    localparam int DEPTH_W = 6;
    localparam int PLY_W   = 6;
    localparam int BOUND_W = 2;
    localparam int AGE_W   = 8;
    localparam int THR_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [THR_W-1:0] THR_RESET = 15'd29000;

    typedef enum logic [1:0] {
        MODE_PROBE  = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [BOUND_W-1:0] {
        BOUND_UPPER = 2'd0,
        BOUND_LOWER = 2'd1,
        BOUND_EXACT = 2'd2,
        BOUND_NONE  = 2'd3
    } bound_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MATE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE      = 2'd1;

    // packed so that move sits at bit 0 and age at the top
    typedef struct packed {
        logic [AGE_W-1:0]          age;
        logic [BOUND_W-1:0]        bound;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
    } payload_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        payload_t         payload;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        mode_t                     mode;
        logic [KEY_W-1:0]          key;
        logic [PLY_W-1:0]          ply;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        bound;
    } cmd_t;

    typedef struct packed {
        logic                      key_found;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] score;
        logic                      cutoff;
        logic                      replaced;
    } result_t;

endpackage

// ===== hdl/transposition_table_engine.sv =====
// top level of the transposition table engine: control, configuration and table memory
// probe or store: a table read, then the lookup state evaluates and writes back, then the done
//   beat; busy holds off a new command until the entry read-modify-write is through
// clear: one entry zeroed per cycle, then the done beat
// reset: busy while a sweep zeroes the table; configuration writes are taken meanwhile.
//   results are strobed on done; the receiver cannot stall
module transposition_table_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    // command beat
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         mode,
    input  logic [tte_pkg::KEY_W-1:0]          position_key,
    input  logic [tte_pkg::PLY_W-1:0]          ply,
    input  logic [tte_pkg::DEPTH_W-1:0]        search_depth,
    input  logic signed [tte_pkg::SCORE_W-1:0] alpha,
    input  logic signed [tte_pkg::SCORE_W-1:0] beta,
    input  logic [tte_pkg::MOVE_W-1:0]         move_in,
    input  logic signed [tte_pkg::SCORE_W-1:0] score_in,
    input  logic [tte_pkg::BOUND_W-1:0]        bound_kind,
    // result beat
    output logic                               done,
    output logic                               key_found,
    output logic [tte_pkg::MOVE_W-1:0]         move_out,
    output logic signed [tte_pkg::SCORE_W-1:0] score_out,
    output logic                               cutoff,
    output logic                               replaced,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tte_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tte_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tte_pkg::*;

    // one-hot control states
    typedef enum logic [3:0] {
        ST_INIT   = 4'b0001,   // sweep after reset
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,   // read data available, evaluate and write back
        ST_CLEAR  = 4'b1000    // sweep for a clear command
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     sweep_cnt_reg, sweep_cnt_next;
    logic [THR_W-1:0]     mate_thr_reg, mate_thr_next;
    logic [AGE_W-1:0]     age_reg, age_next;
    logic                 done_reg, done_next;
    result_t              res_reg, res_next;
    cmd_t                 cmd_reg, cmd_next;

    logic                 accept;
    logic                 cfg_wr;
    logic                 sweep_last;
    logic                 clear_done;

    // table memory: key and payload side by side in one word
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    entry_t               ram_rdata;
    logic [ENTRY_W-1:0]   ram_rdata_raw;

    result_t              eval_res;
    logic                 eval_wr;
    entry_t               eval_entry;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign sweep_last = (sweep_cnt_reg == {IDX_W{1'b1}});
    assign clear_done = (state_reg == ST_CLEAR) && sweep_last;

    // the read address follows the key port so the accepted key is sampled at the accept edge
    tte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (position_key[IDX_W-1:0]),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = entry_t'(ram_rdata_raw);

    tte_eval u_eval (
        .cmd      (cmd_reg),
        .rd_entry (ram_rdata),
        .mate_thr (mate_thr_reg),
        .age      (age_reg),
        .res      (eval_res),
        .wr_en    (eval_wr),
        .wr_entry (eval_entry)
    );

    // memory write: sweep writes zeros, lookup writes the replacement entry
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cmd_reg.key[IDX_W-1:0];
        ram_wdata = eval_entry;
        if ((state_reg == ST_INIT) || (state_reg == ST_CLEAR))
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_LOOKUP)
        begin
            ram_we = eval_wr;
        end
    end

    // command capture
    always_comb
    begin
        cmd_next = cmd_reg;
        if (accept)
        begin
            cmd_next.mode  = mode_t'(mode);
            cmd_next.key   = position_key;
            cmd_next.ply   = ply;
            cmd_next.depth = search_depth;
            cmd_next.alpha = alpha;
            cmd_next.beta  = beta;
            cmd_next.move  = move_in;
            cmd_next.score = score_in;
            cmd_next.bound = bound_kind;
        end
    end

    // control sequence
    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    sweep_cnt_next = '0;
                    if (mode == MODE_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_LOOKUP:
            begin
                done_next  = 1'b1;
                res_next   = eval_res;
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_last)
                begin
                    done_next  = 1'b1;
                    res_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration registers; a finished clear returns the age to zero
    always_comb
    begin
        mate_thr_next = mate_thr_reg;
        age_next      = age_reg;
        if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_MATE_THR: mate_thr_next = cfg_data[THR_W-1:0];
                CFG_AGE:      age_next      = cfg_data[AGE_W-1:0];
                default:      mate_thr_next = mate_thr_reg;
            endcase
        end
        if (clear_done)
        begin
            age_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_cnt_reg <= '0;
            done_reg      <= 1'b0;
            mate_thr_reg  <= THR_RESET;
            age_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            done_reg      <= done_next;
            mate_thr_reg  <= mate_thr_next;
            age_reg       <= age_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    assign done      = done_reg;
    assign key_found = res_reg.key_found;
    assign move_out  = res_reg.move;
    assign score_out = res_reg.score;
    assign cutoff    = res_reg.cutoff;
    assign replaced  = res_reg.replaced;

endmodule

// ===== hdl/tte_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/tte_eval.sv =====
// probe and store evaluation of one command against the entry read from the table
module tte_eval (
    input  tte_pkg::cmd_t                 cmd,
    input  tte_pkg::entry_t               rd_entry,
    input  logic [tte_pkg::THR_W-1:0]     mate_thr,
    input  logic [tte_pkg::AGE_W-1:0]     age,
    output tte_pkg::result_t              res,
    output logic                          wr_en,
    output tte_pkg::entry_t               wr_entry
);
    import tte_pkg::*;

    logic               key_hit;
    logic               deep_enough;
    logic signed [16:0] thr17;
    logic signed [16:0] ply17;
    logic signed [16:0] s_stored;
    logic signed [16:0] s_adj;
    logic signed [16:0] alpha17;
    logic signed [16:0] beta17;
    logic signed [16:0] s_out;
    logic               cut;
    logic signed [17:0] thr18;
    logic signed [17:0] ply18;
    logic signed [17:0] s_in;
    logic signed [17:0] w_sum;
    logic signed [SCORE_W-1:0] w_score;
    logic [8:0]         depth_ext;
    logic [DEPTH_W-1:0] depth_sat;
    logic               replace;

    // probe path
    always_comb
    begin
        key_hit     = (rd_entry.key == cmd.key);
        deep_enough = (rd_entry.payload.depth >= cmd.depth);
        thr17    = signed'({2'b00, mate_thr});
        ply17    = signed'({11'b0, cmd.ply});
        s_stored = signed'({rd_entry.payload.score[SCORE_W-1], rd_entry.payload.score});
        alpha17  = signed'({cmd.alpha[SCORE_W-1], cmd.alpha});
        beta17   = signed'({cmd.beta[SCORE_W-1], cmd.beta});
        if (s_stored > thr17)
        begin
            s_adj = s_stored - ply17;
        end
        else if (s_stored < -thr17)
        begin
            s_adj = s_stored + ply17;
        end
        else
        begin
            s_adj = s_stored;
        end
        s_out = s_adj;
        cut   = 1'b0;
        case (rd_entry.payload.bound)
            BOUND_UPPER:
            begin
                if (s_adj <= alpha17)
                begin
                    s_out = alpha17;
                    cut   = 1'b1;
                end
            end
            BOUND_LOWER:
            begin
                if (s_adj >= beta17)
                begin
                    s_out = beta17;
                    cut   = 1'b1;
                end
            end
            BOUND_EXACT: cut = 1'b1;
            default:     cut = 1'b0;
        endcase
    end

    // store path: mate scores move away from the root, saturating
    always_comb
    begin
        thr18 = signed'({3'b000, mate_thr});
        ply18 = signed'({12'b0, cmd.ply});
        s_in  = signed'({{2{cmd.score[SCORE_W-1]}}, cmd.score});
        if (s_in > thr18)
        begin
            w_sum = s_in + ply18;
        end
        else if (s_in < -thr18)
        begin
            w_sum = s_in - ply18;
        end
        else
        begin
            w_sum = s_in;
        end
        if (w_sum > 18'sd32767)
        begin
            w_score = 16'sh7FFF;
        end
        else if (w_sum < -18'sd32768)
        begin
            w_score = 16'sh8000;
        end
        else
        begin
            w_score = w_sum[SCORE_W-1:0];
        end

        depth_ext = {3'b000, cmd.depth};
        if (depth_ext >= 9'(DEPTH_LIMIT))
        begin
            depth_sat = DEPTH_W'(DEPTH_LIMIT - 1);
        end
        else
        begin
            depth_sat = cmd.depth;
        end

        replace = (rd_entry.key == '0)
               || (rd_entry.payload.age < age)
               || ((rd_entry.payload.age == age) && (rd_entry.payload.depth < depth_sat));

        wr_entry.key           = cmd.key;
        wr_entry.payload.move  = cmd.move;
        wr_entry.payload.score = w_score;
        wr_entry.payload.depth = depth_sat;
        wr_entry.payload.bound = cmd.bound;
        wr_entry.payload.age   = age;
    end

    always_comb
    begin
        res   = '0;
        wr_en = 1'b0;
        unique case (cmd.mode)
            MODE_PROBE:
            begin
                if (key_hit)
                begin
                    res.key_found = 1'b1;
                    res.move      = rd_entry.payload.move;
                    if (deep_enough)
                    begin
                        res.score  = s_out[SCORE_W-1:0];
                        res.cutoff = cut;
                    end
                end
            end
            MODE_STORE:
            begin
                wr_en        = replace;
                res.replaced = replace;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule
